[rtl/atd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atd_pkg
// Shared constants and types for the accelerometer tap detector.
// ----------------------------------------------------------------------------

package atd_pkg;

    localparam int HIST_LEN   = 8;
    localparam int PTR_W      = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int AXES       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int SENS_W     = 15;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;

    localparam logic [SENS_W-1:0] SENS_RESET = 15'd100;

    // Axis order inside tdata, from the lowest bits up
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [AXES-1:0]     axis_bits_t;

endpackage

`default_nettype wire

[rtl/accel_tap_detector_core.sv]
`default_nettype none
// Pipeline: an accepted input transaction reaches m_tvalid through the input register, then the
//   result register.
// Throughput: 1 transaction per cycle; the input register and the result register advance
//   together whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous): history and previous samples clear to zero, ring pointer to
//   zero, all axes armed, sensitivity to 100, both pipeline registers empty.
// ----------------------------------------------------------------------------
// accel_tap_detector_core
// Three-axis tap detector: tracks per-axis sample deltas in a short ring and
// flags a tap when an armed axis sees a delta above the sensitivity.
// ----------------------------------------------------------------------------

module accel_tap_detector_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // Input samples: [15:0] accel_x, [31:16] accel_y, [47:32] accel_z (signed)
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [atd_pkg::S_TDATA_W-1:0]  s_tdata,

    // Results: [0] tap_x, [1] tap_y, [2] tap_z, [7:3] zero
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [atd_pkg::M_TDATA_W-1:0]       m_tdata,

    // Sensitivity register write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [atd_pkg::SENS_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------
    // Configuration: always ready, take the value on a completed transaction
    // ------------------------------------------------------------------
    logic [atd_pkg::SENS_W-1:0] sens_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg <= atd_pkg::SENS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            sens_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // load_en moves the input register into the result register and
    // commits the state update for that sample.
    // ------------------------------------------------------------------
    logic                                   in_valid_reg;
    logic [atd_pkg::S_TDATA_W-1:0]          in_data_reg;
    logic                                   out_valid_reg;
    atd_pkg::axis_bits_t                    tap_reg;
    logic                                   advance;
    logic                                   load_en;

    assign advance  = !out_valid_reg || m_tready;
    assign load_en  = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload register needs no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Detector state
    // ------------------------------------------------------------------
    atd_pkg::sample_t   hist_reg [atd_pkg::HIST_LEN][atd_pkg::AXES];
    atd_pkg::sample_t   prev_reg [atd_pkg::AXES];
    atd_pkg::ptr_t      wptr_reg;
    atd_pkg::axis_bits_t armed_reg;

    atd_pkg::ptr_t      wptr_next;
    atd_pkg::sample_t   delta [atd_pkg::AXES];
    atd_pkg::axis_bits_t jump;
    atd_pkg::axis_bits_t tap_next;
    atd_pkg::axis_bits_t armed_next;

    // Advance the ring pointer before the write, wrapping at the ring length
    always_comb begin
        if (wptr_reg == atd_pkg::PTR_W'(atd_pkg::HIST_LEN - 1)) begin
            wptr_next = '0;
        end else begin
            wptr_next = wptr_reg + atd_pkg::PTR_W'(1);
        end
    end

    // Absolute delta per axis; a 17-bit difference covers the full swing
    always_comb begin
        logic signed [atd_pkg::SAMPLE_W:0] cur;
        logic signed [atd_pkg::SAMPLE_W:0] prv;
        logic signed [atd_pkg::SAMPLE_W:0] diff;
        logic        [atd_pkg::SAMPLE_W:0] mag;
        for (int a = 0; a < atd_pkg::AXES; a++) begin
            cur  = {in_data_reg[a*atd_pkg::SAMPLE_W + atd_pkg::SAMPLE_W - 1],
                    in_data_reg[a*atd_pkg::SAMPLE_W +: atd_pkg::SAMPLE_W]};
            prv  = {prev_reg[a][atd_pkg::SAMPLE_W-1], prev_reg[a]};
            diff = cur - prv;
            mag  = diff[atd_pkg::SAMPLE_W] ? 17'(-diff) : 17'(diff);
            delta[a] = mag[atd_pkg::SAMPLE_W-1:0];
        end
    end

    // Window compare over the ring as it will look after this write
    always_comb begin
        atd_pkg::sample_t entry;
        for (int a = 0; a < atd_pkg::AXES; a++) begin
            jump[a] = 1'b0;
            for (int i = 0; i < atd_pkg::HIST_LEN; i++) begin
                if (wptr_next == atd_pkg::PTR_W'(i)) begin
                    entry = delta[a];
                end else begin
                    entry = hist_reg[i][a];
                end
                if (entry > atd_pkg::SAMPLE_W'(sens_reg)) begin
                    jump[a] = 1'b1;
                end
            end
        end
    end

    // Fire on a jump while armed; disarm on any jump, re-arm on a quiet tick
    always_comb begin
        for (int a = 0; a < atd_pkg::AXES; a++) begin
            tap_next[a]   = jump[a] && armed_reg[a];
            armed_next[a] = !jump[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            armed_reg <= '1;
            for (int a = 0; a < atd_pkg::AXES; a++) begin
                prev_reg[a] <= '0;
                for (int i = 0; i < atd_pkg::HIST_LEN; i++) begin
                    hist_reg[i][a] <= '0;
                end
            end
        end else if (load_en) begin
            wptr_reg  <= wptr_next;
            armed_reg <= armed_next;
            for (int a = 0; a < atd_pkg::AXES; a++) begin
                prev_reg[a] <= in_data_reg[a*atd_pkg::SAMPLE_W +: atd_pkg::SAMPLE_W];
                hist_reg[wptr_next][a] <= delta[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold while the downstream side stalls
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            tap_reg <= tap_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(atd_pkg::M_TDATA_W - atd_pkg::AXES)'(0),
                       tap_reg[atd_pkg::AXIS_Z],
                       tap_reg[atd_pkg::AXIS_Y],
                       tap_reg[atd_pkg::AXIS_X]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    genvar ga;
    for (ga = 0; ga < atd_pkg::AXES; ga++) begin : g_axis_chk
        // A reported tap always leaves the axis disarmed
        a_tap_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
            load_en && tap_next[ga] |=> !armed_reg[ga])
            else $error("axis %0d still armed after a tap", ga);

        // Re-arming only follows a committed sample without a jump
        a_rearm_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
            $rose(armed_reg[ga]) && $past(aresetn) |-> $past(load_en && !jump[ga]))
            else $error("axis %0d re-armed without a quiet sample", ga);
    end

    // Ring pointer moves only when a sample is committed
    a_wptr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !load_en |=> $stable(wptr_reg))
        else $error("ring pointer moved without a committed sample");

    // A new result appears only from a committed sample
    a_out_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(load_en))
        else $error("result valid without a committed sample");

endmodule

`default_nettype wire
